### design/lfs_pkg.sv
package lfs_pkg;

    localparam int FRAME_WIDTH  = 150;
    localparam int FRAME_HEIGHT = 100;

    localparam int ROW_W   = 7;
    localparam int COL_W   = 8;
    localparam int PIX_W   = 8;
    localparam int SPEED_W = 17;
    localparam int BASE_W  = 15;
    localparam int THR_W   = 8;
    localparam int SUM_W   = 24;
    localparam int CNT_W   = 16;
    localparam int MEAN_W  = 8;
    localparam int QUO_W   = 16;

    localparam logic [CNT_W-1:0] CNT_CAP = '1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_THRESHOLD = 2'd2;

    localparam logic [BASE_W-1:0] BASE_SPEED_RST      = 15'd6400;
    localparam logic [THR_W-1:0]  WHITE_THRESHOLD_RST = 8'd250;
    localparam logic [THR_W-1:0]  BLACK_THRESHOLD_RST = 8'd5;

    // Centre of the row in Q.8.
    localparam logic [SPEED_W-1:0] E_OFFSET = SPEED_W'((FRAME_WIDTH - 1) * 128);

    // Division by ten as a multiplication by a scaled reciprocal.
    localparam int MUL_X_W     = 19;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 23;
    localparam int PROD_W      = MUL_X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 20'd838861;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef logic [2:0] t_mode;
    localparam t_mode MODE_FINISH = 3'd0;
    localparam t_mode MODE_TOP    = 3'd1;
    localparam t_mode MODE_LEFT   = 3'd2;
    localparam t_mode MODE_RIGHT  = 3'd3;
    localparam t_mode MODE_SPIN   = 3'd4;

    typedef struct packed {
        t_mode              mode;
        logic               finish;
        logic [SUM_W-1:0]   sum;
        logic [CNT_W-1:0]   cnt;
        logic [BASE_W-1:0]  base;
    } t_snap;

endpackage

### design/lfs_if.sv
interface lfs_pix_if import lfs_pkg::*;;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] pixel_row;
    logic [COL_W-1:0] pixel_col;
    logic [PIX_W-1:0] intensity;
    logic             frame_end;

    modport source (output valid, output pixel_row, output pixel_col, output intensity,
                    output frame_end, input ready);
    modport sink (input valid, input pixel_row, input pixel_col, input intensity,
                  input frame_end, output ready);
endinterface

interface lfs_spd_if import lfs_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic                      finish_seen;

    modport source (output valid, output left_speed, output right_speed,
                    output finish_seen, input ready);
    modport sink (input valid, input left_speed, input right_speed,
                  input finish_seen, output ready);
endinterface

### design/lfs_front.sv
module lfs_front import lfs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BASE_W-1:0]    i_cfg_data,
    lfs_pix_if.sink              i_pix,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_snap                o_snap
);

    logic [BASE_W-1:0] r_base;
    logic [THR_W-1:0]  r_white_thr;
    logic [THR_W-1:0]  r_black_thr;
    logic              r_finish;
    logic              r_left;
    logic              r_right;
    logic              r_top_white;
    logic              r_top_dark;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;

    logic              n_finish;
    logic              n_left;
    logic              n_right;
    logic              n_top_white;
    logic              n_top_dark;
    logic [SUM_W-1:0]  n_sum;
    logic [CNT_W-1:0]  n_cnt;

    logic accept;
    logic in_frame;
    logic top_px;
    logic is_white;
    logic is_dark;
    logic add_col;

    assign i_pix.ready = !i_q_full;
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        in_frame = (i_pix.pixel_row < ROW_W'(FRAME_HEIGHT))
                && (i_pix.pixel_col < COL_W'(FRAME_WIDTH));
        top_px   = in_frame && (i_pix.pixel_row == '0);
        is_white = i_pix.intensity > r_white_thr;
        is_dark  = i_pix.intensity < r_black_thr;
        add_col  = top_px && is_white && (r_cnt != CNT_CAP);

        n_left      = r_left || (in_frame && is_white && (i_pix.pixel_col == '0));
        n_right     = r_right || (in_frame && is_white
                                  && (i_pix.pixel_col == COL_W'(FRAME_WIDTH - 1)));
        n_top_white = r_top_white || (top_px && is_white);
        n_top_dark  = r_top_dark || (top_px && is_dark);
        n_sum       = add_col ? r_sum + SUM_W'(i_pix.pixel_col) : r_sum;
        n_cnt       = add_col ? r_cnt + CNT_W'(1) : r_cnt;
        n_finish    = r_finish || n_top_dark;

        o_snap.finish = n_finish;
        o_snap.sum    = n_sum;
        o_snap.cnt    = n_cnt;
        o_snap.base   = r_base;
        if (n_finish) begin
            o_snap.mode = MODE_FINISH;
        end else if (n_top_white) begin
            o_snap.mode = MODE_TOP;
        end else if (n_left) begin
            o_snap.mode = MODE_LEFT;
        end else if (n_right) begin
            o_snap.mode = MODE_RIGHT;
        end else begin
            o_snap.mode = MODE_SPIN;
        end
    end

    assign o_push = accept && i_pix.frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_SPEED_RST;
            r_white_thr <= WHITE_THRESHOLD_RST;
            r_black_thr <= BLACK_THRESHOLD_RST;
            r_finish    <= 1'b0;
            r_left      <= 1'b0;
            r_right     <= 1'b0;
            r_top_white <= 1'b0;
            r_top_dark  <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_SPEED:      r_base      <= i_cfg_data;
                    CFG_WHITE_THRESHOLD: r_white_thr <= i_cfg_data[THR_W-1:0];
                    CFG_BLACK_THRESHOLD: r_black_thr <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (i_pix.frame_end) begin
                    r_finish    <= n_finish;
                    r_left      <= 1'b0;
                    r_right     <= 1'b0;
                    r_top_white <= 1'b0;
                    r_top_dark  <= 1'b0;
                    r_sum       <= '0;
                    r_cnt       <= '0;
                end else begin
                    r_left      <= n_left;
                    r_right     <= n_right;
                    r_top_white <= n_top_white;
                    r_top_dark  <= n_top_dark;
                    r_sum       <= n_sum;
                    r_cnt       <= n_cnt;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_cnt == '0) && (r_sum == '0) && !r_top_white && !r_top_dark)
        else $error("per-frame state not cleared after frame end");
`endif

endmodule

### design/lfs_queue.sv
module lfs_queue import lfs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_snap i_snap,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_snap o_snap
);

    t_snap              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_snap  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("frame summary written into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("frame summary taken from an empty queue");
`endif

endmodule

### design/lfs_back.sv
module lfs_back import lfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_snap      i_snap,
    output logic       o_pop,
    lfs_spd_if.source  o_spd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MULA = 3'd2;
    localparam logic [2:0] ST_MULB = 3'd3;
    localparam logic [2:0] ST_FORM = 3'd4;

    logic [2:0]                r_state;
    t_snap                     r_snap;
    logic [SUM_W-1:0]          r_rem;
    logic [MEAN_W-1:0]         r_q;
    logic [2:0]                r_step;
    logic                      r_eneg;
    logic [PROD_W-1:0]         r_prod;
    logic [QUO_W-1:0]          r_qa;
    logic                      r_ov;
    logic signed [SPEED_W-1:0] r_left;
    logic signed [SPEED_W-1:0] r_right;
    logic                      r_fin;

    logic [SUM_W-1:0]          trial;
    logic                      ge;
    logic signed [SPEED_W-1:0] e_val;
    logic [SPEED_W-1:0]        e_abs;
    logic [MUL_X_W-1:0]        base_x;
    logic [MUL_X_W-1:0]        b7;
    logic [MUL_X_W-1:0]        b13;
    logic [MUL_X_W-1:0]        x_a;
    logic [QUO_W-1:0]          qb;
    logic signed [SPEED_W-1:0] base_s;
    logic signed [SPEED_W-1:0] half_s;
    logic signed [SPEED_W-1:0] d_s;
    logic signed [SPEED_W-1:0] n_left;
    logic signed [SPEED_W-1:0] n_right;
    logic                      out_free;

    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign out_free = !r_ov || o_spd.ready;

    always_comb begin
        trial  = SUM_W'(r_snap.cnt) << r_step;
        ge     = r_rem >= trial;

        e_val  = $signed({1'b0, r_q, 8'b0}) - $signed(E_OFFSET);
        e_abs  = e_val[SPEED_W-1] ? SPEED_W'(-e_val) : SPEED_W'(e_val);

        base_x = MUL_X_W'(r_snap.base);
        b7     = (base_x << 3) - base_x;
        b13    = (base_x << 3) + (base_x << 2) + base_x;
        x_a    = (r_snap.mode == MODE_TOP) ? MUL_X_W'(e_abs) : b7;

        qb     = r_prod[PROD_W-1:RECIP_SHIFT];
        base_s = $signed(SPEED_W'(r_snap.base));
        half_s = $signed(SPEED_W'(r_snap.base[BASE_W-1:1]));
        d_s    = r_eneg ? -$signed({1'b0, r_qa}) : $signed({1'b0, r_qa});

        case (r_snap.mode)
            MODE_FINISH: begin
                n_left  = base_s;
                n_right = base_s;
            end
            MODE_TOP: begin
                n_left  = base_s + d_s;
                n_right = base_s - d_s;
            end
            MODE_LEFT: begin
                n_left  = $signed({1'b0, r_qa});
                n_right = $signed({1'b0, qb});
            end
            MODE_RIGHT: begin
                n_left  = $signed({1'b0, qb});
                n_right = $signed({1'b0, r_qa});
            end
            default: begin
                n_left  = half_s;
                n_right = -half_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_snap <= i_snap;
            r_rem  <= i_snap.sum;
            r_q    <= '0;
            r_step <= 3'(MEAN_W - 1);
        end
        if (r_state == ST_DIV) begin
            r_q[r_step] <= ge;
            if (ge) begin
                r_rem <= r_rem - trial;
            end
            r_step <= r_step - 3'd1;
        end
        if (r_state == ST_MULA) begin
            r_eneg <= e_val[SPEED_W-1];
            r_prod <= x_a * RECIP_TEN;
        end
        if (r_state == ST_MULB) begin
            r_qa   <= r_prod[PROD_W-1:RECIP_SHIFT];
            r_prod <= b13 * RECIP_TEN;
        end
        if ((r_state == ST_FORM) && out_free) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_fin   <= r_snap.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if ((r_state == ST_FORM) && out_free) begin
                r_ov <= 1'b1;
            end else if (o_spd.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        if ((i_snap.mode == MODE_TOP) && (i_snap.cnt != '0)) begin
                            r_state <= ST_DIV;
                        end else begin
                            r_state <= ST_MULA;
                        end
                    end
                end
                ST_DIV: begin
                    if (r_step == '0) begin
                        r_state <= ST_MULA;
                    end
                end
                ST_MULA: r_state <= ST_MULB;
                ST_MULB: r_state <= ST_FORM;
                ST_FORM: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_spd.valid       = r_ov;
    assign o_spd.left_speed  = r_left;
    assign o_spd.right_speed = r_right;
    assign o_spd.finish_seen = r_fin;

`ifndef NO_ASSERTIONS
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) && (r_step == '0) |=> r_state == ST_MULA)
        else $error("mean division did not finish after its last step");
    a_pop_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_DIV) || (r_state == ST_MULA))
        else $error("frame summary taken without starting the speed computation");
`endif

endmodule

### design/line_follow_steering.sv
// Pixels: one word per clock; ready falls only while both frame summaries in the queue wait.
// From the frame-end pixel, its summary is queued and then turned into speeds through mean division
// (only when steering on the top row), first multiply, second multiply and forming, plus any wait on the output side.
// The speed sequencer handles one frame at a time; a two-entry queue decouples it from pixels.
// Reset is synchronous and active low: it clears all frame state and the finished mark and
// loads base speed 6400, white threshold 250 and black threshold 5.
module line_follow_steering import lfs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BASE_W-1:0]    i_cfg_data,
    lfs_pix_if.sink              i_pix,
    lfs_spd_if.source            o_spd
);

    logic  q_push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    t_snap snap_in;
    t_snap snap_out;

    lfs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_snap     (snap_in)
    );

    lfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_snap  (snap_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_snap  (snap_out)
    );

    lfs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_snap    (snap_out),
        .o_pop     (q_pop),
        .o_spd     (o_spd)
    );

endmodule
